>>> sv/ipc_pkg.sv
package ipc_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int CHAR_W      = 8;
   localparam int PREC_W      = 2;

   localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
   localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
   localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              char_valid;
      logic              run_last;
      logic              expr_done;
      logic              overflow_seen;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } emit_type;

   function automatic logic [PREC_W-1:0] prec_of(logic [CHAR_W-1:0] c);
      logic [PREC_W-1:0] p;
      unique case (c)
         CH_CARET:           p = PREC_W'(3);
         CH_STAR, CH_SLASH:  p = PREC_W'(2);
         CH_PLUS, CH_MINUS:  p = PREC_W'(1);
         default:            p = PREC_W'(0);
      endcase
      return p;
   endfunction

   function automatic logic is_alnum(logic [CHAR_W-1:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

endpackage

>>> sv/infix_to_postfix_converter_core.sv
// Channel  Dir  Ports                         Payload
// req      in   req_tvalid/tready/tdata/tlast  in_char, expr_end
// rsp      out  rsp_tvalid/tready/tdata/tuser/tlast
//                                              out_char, char_valid, expr_done,
//                                              overflow_seen, run_last
//
// An item is taken in IDLE and ends in FINISH; each stack entry that the pop loop
// inspects costs a READ and a CHECK step, set by the operator stack RAM and its
// registered read port; a push costs a PUSH step and an empty-stack scan a READ.
// Reset is synchronous; the stack RAM is not cleared, only its count.
// While rsp is stalled with a result held, the sequencer waits before emitting.
// req_tready is high only while no item is in progress.
module infix_to_postfix_converter_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,   // expr_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [2:0] rsp_tuser,   // [0] char_valid, [1] expr_done, [2] overflow_seen
   output logic       rsp_tlast    // run_last
);

   import ipc_pkg::*;

   emit_type     emit;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff, rsp_in;

   assign out_free = !rsp_valid_ff || rsp_tready;

   ipc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_char (req_tdata),
      .req_end  (req_tlast),
      .out_free (out_free),
      .emit     (emit)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (emit.valid) begin
         rsp_in       = emit.item;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.out_char;
   assign rsp_tuser  = {rsp_ff.overflow_seen, rsp_ff.expr_done, rsp_ff.char_valid};
   assign rsp_tlast  = rsp_ff.run_last;

endmodule

>>> sv/ipc_ram.sv
module ipc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ipc_ctrl.sv
module ipc_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_char,
   input  logic                     req_end,
   input  logic                     out_free,
   output ipc_pkg::emit_type        emit
);

   import ipc_pkg::*;

   typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_CHECK, ST_PUSH, ST_FINISH} state_type;
   typedef enum logic [1:0] {MODE_CLOSE, MODE_OP, MODE_FLUSH} mode_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [PREC_W-1:0] prec_ff, prec_in;
   logic              end_ff, end_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [CHAR_W-1:0] pend_char_ff, pend_char_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CHAR_W-1:0] top;
   logic              pop;
   logic [CNT_W-1:0]  count_dec;

   assign count_dec = count_ff - CNT_W'(1);
   assign rd_addr   = count_dec[ADDR_W-1:0];
   assign wr_addr   = count_ff[ADDR_W-1:0];

   ipc_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(char_ff),
      .rd_addr(rd_addr),
      .rd_data(top)
   );

   always_comb begin
      unique case (mode_ff)
         MODE_CLOSE: pop = (top != CH_LPAREN);
         MODE_OP:    pop = (prec_of(top) >= prec_ff);
         default:    pop = 1'b1;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      char_in       = char_ff;
      prec_in       = prec_ff;
      end_in        = end_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      wr_en         = 1'b0;
      emit          = '0;
      req_ready     = (state_ff == ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               char_in = req_char;
               end_in  = req_end;
               prec_in = prec_of(req_char);
               mode_in = MODE_OP;
               if (is_alnum(req_char)) begin
                  pend_valid_in = 1'b1;
                  pend_char_in  = req_char;
                  if (req_end) begin
                     mode_in  = MODE_FLUSH;
                     state_in = ST_READ;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end else if (req_char == CH_LPAREN) begin
                  state_in = ST_PUSH;
               end else if (req_char == CH_RPAREN) begin
                  mode_in  = MODE_CLOSE;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (count_ff == '0) begin
               unique case (mode_ff)
                  MODE_OP: state_in = ST_PUSH;
                  MODE_CLOSE: begin
                     if (end_ff) begin
                        mode_in  = MODE_FLUSH;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_FINISH;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (pop) begin
               if (!pend_valid_ff || out_free) begin
                  emit.valid              = pend_valid_ff;
                  emit.item.out_char      = pend_char_ff;
                  emit.item.char_valid    = 1'b1;
                  emit.item.run_last      = 1'b0;
                  emit.item.expr_done     = 1'b0;
                  emit.item.overflow_seen = ovf_ff;
                  pend_valid_in           = 1'b1;
                  pend_char_in            = top;
                  count_in                = count_dec;
                  state_in                = ST_READ;
               end
            end else if (mode_ff == MODE_CLOSE) begin
               count_in = count_dec;
               if (end_ff) begin
                  mode_in  = MODE_FLUSH;
                  state_in = ST_READ;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (count_ff >= CNT_W'(STACK_DEPTH)) begin
               ovf_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
            if (end_ff) begin
               mode_in  = MODE_FLUSH;
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff || end_ff) begin
               if (out_free) begin
                  emit.valid              = 1'b1;
                  emit.item.out_char      = pend_valid_ff ? pend_char_ff : CH_NUL;
                  emit.item.char_valid    = pend_valid_ff;
                  emit.item.run_last      = 1'b1;
                  emit.item.expr_done     = end_ff;
                  emit.item.overflow_seen = ovf_ff;
                  pend_valid_in           = 1'b0;
                  if (end_ff) begin
                     ovf_in = 1'b0;
                  end
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      char_ff      <= char_in;
      prec_ff      <= prec_in;
      end_ff       <= end_in;
      pend_char_ff <= pend_char_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ipc_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_CHARS = 150;
   localparam int DIR_ROWS = 21;

   typedef enum int {RX_OPEN, RX_COIN, RX_CHOKE} rx_mode_type;
   typedef enum int {SEQ_CLEAN, SEQ_BROKEN, SEQ_NEST, SEQ_NOISE} seq_kind_type;

   typedef struct {
      logic [7:0]   ch;
      logic         last;
      logic         typed;
      rsp_item_type want;
   } dir_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] in_char
   logic       req_tlast = 1'b0;    // expr_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic [2:0] rsp_tuser;           // [0] char_valid, [1] expr_done, [2] overflow_seen
   logic       rsp_tlast;           // run_last

   logic [7:0]   ops [STACK_DEPTH];
   int           ops_depth = 0;
   logic         ops_ovf = 1'b0;
   rsp_item_type step_out[$];
   rsp_item_type postfix_due[$];
   rsp_item_type got_want;
   logic [7:0]   expr_q[$];
   logic [7:0]   op_set [5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

   int          chars_sent = 0;
   int          burst_left = 0;
   int          errors = 0;
   int          quiet_cycles = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;
   int          choke_left = 0;

   dir_row_type dir_tab [DIR_ROWS] = '{
      '{CH_RPAREN, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0}},
      '{"0",       1'b0, 1'b1, '{"0",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_PLUS,   1'b0, 1'b0, '0},
      '{"9",       1'b0, 1'b1, '{"9",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_STAR,   1'b0, 1'b0, '0},
      '{"A",       1'b0, 1'b1, '{"A",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_CARET,  1'b0, 1'b0, '0},
      '{"Z",       1'b0, 1'b1, '{"Z",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_MINUS,  1'b0, 1'b0, '0},
      '{CH_LPAREN, 1'b0, 1'b0, '0},
      '{"a",       1'b0, 1'b1, '{"a",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_SLASH,  1'b0, 1'b0, '0},
      '{"z",       1'b0, 1'b1, '{"z",   1'b1, 1'b1, 1'b0, 1'b0}},
      '{CH_RPAREN, 1'b0, 1'b0, '0},
      '{8'h00,     1'b0, 1'b0, '0},
      '{8'hFF,     1'b0, 1'b0, '0},
      '{CH_RPAREN, 1'b0, 1'b0, '0},
      '{"1",       1'b1, 1'b1, '{"1",   1'b1, 1'b1, 1'b1, 1'b0}},
      '{8'h80,     1'b1, 1'b0, '0},
      '{CH_LPAREN, 1'b0, 1'b0, '0},
      '{CH_LPAREN, 1'b1, 1'b0, '0}
   };

   infix_to_postfix_converter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int op_rank(logic [7:0] c);
      case (c)
         CH_CARET:          return 3;
         CH_STAR, CH_SLASH: return 2;
         CH_PLUS, CH_MINUS: return 1;
         default:           return 0;
      endcase
   endfunction

   function automatic void stack_op(logic [7:0] c);
      if (ops_depth >= STACK_DEPTH) begin
         ops_ovf = 1'b1;
      end else begin
         ops[ops_depth] = c;
         ops_depth++;
      end
   endfunction

   function automatic void shunt_char(logic [7:0] c, logic e);
      logic [7:0]   em[$];
      rsp_item_type r;
      step_out.delete();
      if (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) begin
         em.push_back(c);
      end else if (c == CH_LPAREN) begin
         stack_op(c);
      end else if (c == CH_RPAREN) begin
         while (ops_depth > 0 && ops[ops_depth-1] != CH_LPAREN) begin
            ops_depth--;
            em.push_back(ops[ops_depth]);
         end
         if (ops_depth > 0) ops_depth--;
      end else begin
         while (ops_depth > 0 && op_rank(ops[ops_depth-1]) >= op_rank(c)) begin
            ops_depth--;
            em.push_back(ops[ops_depth]);
         end
         stack_op(c);
      end
      if (e) begin
         while (ops_depth > 0) begin
            ops_depth--;
            em.push_back(ops[ops_depth]);
         end
      end
      for (int k = 0; k < em.size(); k++) begin
         r.out_char = em[k];
         r.char_valid = 1'b1;
         r.run_last = (k == em.size() - 1);
         r.expr_done = e && r.run_last;
         r.overflow_seen = ops_ovf;
         step_out.push_back(r);
      end
      if (e && em.size() == 0) begin
         r = '0;
         r.run_last = 1'b1;
         r.expr_done = 1'b1;
         r.overflow_seen = ops_ovf;
         step_out.push_back(r);
      end
      if (e) ops_ovf = 1'b0;
   endfunction

   function automatic logic [7:0] pick_operand();
      int n;
      n = $urandom_range(0, 61);
      if (n < 10) return 8'(8'h30 + n);
      if (n < 36) return 8'(8'h41 + (n - 10));
      return 8'(8'h61 + (n - 36));
   endfunction

   function automatic void grow_expr(int lvl);
      int terms;
      terms = $urandom_range(1, (lvl < 3) ? 4 : 2);
      for (int t = 0; t < terms; t++) begin
         if (t > 0) expr_q.push_back(op_set[$urandom_range(0, 4)]);
         if (lvl < 3 && $urandom_range(0, 3) == 0) begin
            expr_q.push_back(CH_LPAREN);
            grow_expr(lvl + 1);
            expr_q.push_back(CH_RPAREN);
         end else begin
            expr_q.push_back(pick_operand());
         end
      end
   endfunction

   // call at a falling edge; returns at the falling edge after the item is taken
   task automatic send_char(input logic [7:0] c, input logic e, input logic typed,
                            input rsp_item_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shunt_char(c, e);
      if (typed) begin
         postfix_due.push_back(want);
      end else begin
         foreach (step_out[i]) postfix_due.push_back(step_out[i]);
      end
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_expr();
      for (int i = 0; i < expr_q.size(); i++) begin
         send_char(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
      end
   endtask

   task automatic build_nest();
      int n;
      n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
      expr_q.delete();
      repeat (n) expr_q.push_back(CH_LPAREN);
      if ($urandom_range(0, 1) == 0) begin
         expr_q.push_back(pick_operand());
      end else begin
         grow_expr(1);
      end
   endtask

   initial begin
      seq_kind_type kind;
      int           goal;
      int           idx;
      int           pick;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].want);
      end

      // full stack with a maximal flush first
      expr_q.delete();
      repeat (STACK_DEPTH + 2) expr_q.push_back(CH_LPAREN);
      expr_q.push_back(pick_operand());
      send_expr();

      goal = chars_sent + RANDOM_CHARS;
      while (chars_sent < goal) begin
         pick = $urandom_range(0, 9);
         kind = (pick < 6) ? SEQ_CLEAN : (pick < 8) ? SEQ_BROKEN :
                (pick < 9) ? SEQ_NEST : SEQ_NOISE;
         case (kind)
            SEQ_CLEAN: begin
               expr_q.delete();
               grow_expr(0);
               send_expr();
            end
            SEQ_BROKEN: begin
               expr_q.delete();
               grow_expr(0);
               idx = $urandom_range(0, expr_q.size() - 1);
               case ($urandom_range(0, 2))
                  0: expr_q[idx] = 8'($urandom_range(0, 255));
                  1: if (expr_q.size() > 1) expr_q.delete(idx);
                  default: expr_q.insert(idx, CH_RPAREN);
               endcase
               send_expr();
            end
            SEQ_NEST: begin
               build_nest();
               send_expr();
            end
            default: begin
               repeat ($urandom_range(1, 6)) begin
                  send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                            1'b0, '0);
               end
            end
         endcase
      end

      req_tvalid <= 1'b0;
      wait (postfix_due.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && postfix_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(8, 60);
      end
      rx_left--;
      case (rx_mode)
         RX_OPEN: rsp_tready <= 1'b1;
         RX_COIN: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (choke_left > 0) begin
               choke_left--;
               rsp_tready <= 1'b0;
            end else begin
               choke_left = $urandom_range(1, 8);
               rsp_tready <= 1'b1;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (postfix_due.size() == 0) begin
            $error("unexpected item: out_char %h tuser %b tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            got_want = postfix_due.pop_front();
            if (rsp_tdata !== got_want.out_char) begin
               $error("out_char: expected %h, got %h", got_want.out_char, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== got_want.char_valid) begin
               $error("char_valid: expected %b, got %b", got_want.char_valid, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tlast !== got_want.run_last) begin
               $error("run_last: expected %b, got %b", got_want.run_last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser[1] !== got_want.expr_done) begin
               $error("expr_done: expected %b, got %b", got_want.expr_done, rsp_tuser[1]);
               errors++;
            end
            if (rsp_tuser[2] !== got_want.overflow_seen) begin
               $error("overflow_seen: expected %b, got %b",
                      got_want.overflow_seen, rsp_tuser[2]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
